[hdl/grid_surface_normal_unit_top_assert.svh]
// Assertion macros for the grid surface normal unit checker.
// Depends on nothing; included by the checker file only.
`ifndef GRID_SURFACE_NORMAL_UNIT_TOP_ASSERT_SVH
`define GRID_SURFACE_NORMAL_UNIT_TOP_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define GSN_ASSERT_IMPLY(lbl, ck, rn, pre, post, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) else $error(msg);

// Next-cycle implication under the active-low reset.
`define GSN_ASSERT_NEXT(lbl, ck, rn, pre, post, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) else $error(msg);

`endif

[hdl/gsn_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and codes of the grid surface normal unit.
// No dependencies; imported by gsn_sqrt, gsn_div, the top level, the checker and the testbench.
package gsn_pkg;
	localparam int MAX_GRID_DEF = 32;
	localparam int CFG_W = 6;
	localparam int ROW_W = 5;
	localparam int COORD_W = 16;
	localparam int NRM_W = 16;
	localparam int STAT_W = 2;
	localparam int DIFF_W = 17;
	localparam int MAG_W = 16;
	localparam int CROSS_W = 34;
	localparam int MUL_W = 30;
	localparam int SUM_W = 62;
	localparam int ROOT_W = 31;
	localparam int NUM_W = 45;
	localparam int QUO_W = 15;
	localparam int FRAC_SH = 14;

	localparam logic [CFG_W-1:0] GRID_RESET = 6'd20;
	localparam logic [QUO_W-1:0] ONE_Q14 = 15'd16384;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_DEG = 2'd1;
	localparam logic [STAT_W-1:0] ST_OOR = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;
endpackage

[hdl/gsn_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gsn_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/gsn_smul.sv]
`timescale 1ns / 1ps
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// No dependencies.
module gsn_smul #(
	parameter int W = 30
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] p
);
	localparam int CW = $clog2(W);

	logic [2*W-1:0] mcand_q;
	logic [W-1:0]   mplier_q;
	logic [2*W-1:0] acc_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic           done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (int'(cnt_q) == W - 1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Accumulate one partial product per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= (2*W)'(a);
			mplier_q <= b;
			acc_q <= '0;
		end else if (run_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign p = acc_q;
endmodule

[hdl/gsn_sqrt.sv]
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle.
// Depends on gsn_pkg for widths.
module gsn_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gsn_pkg::SUM_W-1:0]   s,
	output logic                        done,
	output logic [gsn_pkg::ROOT_W-1:0]  root
);
	import gsn_pkg::*;

	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] res_q;
	logic [SUM_W-1:0] bit_q;
	logic [4:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic [SUM_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (int'(cnt_q) == ROOT_W - 1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= s;
			res_q <= '0;
			bit_q <= SUM_W'(1) << (SUM_W - 2);
		end else if (run_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];
endmodule

[hdl/gsn_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, quotient known below 2^15.
// Depends on gsn_pkg for widths.
module gsn_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gsn_pkg::NUM_W-1:0]   num,
	input  logic [gsn_pkg::ROOT_W-1:0]  den,
	output logic                        done,
	output logic [gsn_pkg::QUO_W-1:0]   quo
);
	import gsn_pkg::*;

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0]       cnt_q;
	logic             run_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (int'(cnt_q) == QUO_W - 1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= NUM_W'(den) << (QUO_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule

[hdl/grid_surface_normal_unit_top.sv]
`timescale 1ns / 1ps
// Top level of the grid surface normal unit: point store, sequencer, result register.
// Depends on gsn_pkg, gsn_ram, gsn_smul, gsn_sqrt and gsn_div.
//
// Usage:
//   Input channel (in_valid / in_stall, block drives in_stall): one transfer per
//   item. cmd = write stores point_x/y/z at (row, col); a write outside the
//   grid in use is dropped. cmd = read returns one result.
//   Output channel (out_valid / out_stall, receiver drives out_stall): one
//   transfer per read, carrying normal_x/y/z (Q1.14) and status.
//   Config channel (cfg_valid / cfg_ready): writes grid_size; ready is always high.
//   Change it only while the block is idle.
// Sequence:
//   Writes are taken back to back. An out-of-range read goes straight to the result
//   stage, a degenerate read after the cross products. A full read runs six cross
//   products and three squares on the bit-serial multiplier, one normalizing shift
//   per cycle, then a square root and three divisions. The block takes one item at
//   a time and holds in_stall high while a read is in progress.
// Reset: clears the sequencer, the output valid and sets grid_size to 20; the
//   point store is not cleared, so read only cells whose points were written.
// Stall: a finished result waits in the output register; the block takes new
//   items meanwhile, and holds a second result until the first is taken.
module grid_surface_normal_unit_top #(
	parameter int MAX_GRID = gsn_pkg::MAX_GRID_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gsn_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic [gsn_pkg::ROW_W-1:0]          row,
	input  logic [gsn_pkg::ROW_W-1:0]          col,
	input  logic signed [gsn_pkg::COORD_W-1:0] point_x,
	input  logic signed [gsn_pkg::COORD_W-1:0] point_y,
	input  logic signed [gsn_pkg::COORD_W-1:0] point_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [gsn_pkg::NRM_W-1:0]   normal_x,
	output logic signed [gsn_pkg::NRM_W-1:0]   normal_y,
	output logic signed [gsn_pkg::NRM_W-1:0]   normal_z,
	output logic [gsn_pkg::STAT_W-1:0]         status
);
	import gsn_pkg::*;

	localparam int DEPTH = MAX_GRID * MAX_GRID;
	localparam int AW = $clog2(DEPTH);
	localparam int GW = $clog2(MAX_GRID + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD0  = 4'd1;
	localparam logic [3:0] S_RD1  = 4'd2;
	localparam logic [3:0] S_RD2  = 4'd3;
	localparam logic [3:0] S_RD3  = 4'd4;
	localparam logic [3:0] S_DIFF = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_MAG  = 4'd7;
	localparam logic [3:0] S_NORM = 4'd8;
	localparam logic [3:0] S_SQ   = 4'd9;
	localparam logic [3:0] S_SQRT = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	localparam logic [CROSS_W-1:0] HI_LIM = CROSS_W'(1) << 30;
	localparam logic [CROSS_W-1:0] LO_LIM = CROSS_W'(1) << 29;

	function automatic logic [DIFF_W-1:0] diff(input coord_t a, input coord_t b);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

	logic [3:0]          state_q;
	logic [CFG_W-1:0]    gsize_q;
	logic [GW-1:0]       g_use;
	logic                accept;
	logic                in_range;
	logic [ROW_W-1:0]    r_q, c_q;
	logic [AW-1:0]       raddr;
	point_t              rdata;
	point_t              p00_q, p10_q, p01_q;
	logic [MAG_W-1:0]    u_mag_q [3];
	logic [MAG_W-1:0]    v_mag_q [3];
	logic                u_neg_q [3];
	logic                v_neg_q [3];
	logic [DIFF_W-1:0]   du [3];
	logic [DIFF_W-1:0]   dv [3];
	logic signed [CROSS_W-1:0] n_q [3];
	logic [CROSS_W-1:0]  a_q [3];
	logic [CROSS_W-1:0]  m_q;
	logic [CROSS_W-1:0]  aval [3];
	logic [CROSS_W-1:0]  mx;
	logic [2:0]          k_q;
	logic [1:0]          ui, vi;
	logic [SUM_W-1:0]    acc_q;
	logic [ROOT_W-1:0]   len_q;
	logic signed [NRM_W-1:0] res_n_q [3];
	logic [STAT_W-1:0]   res_st_q;
	logic                mul_go_q, sqrt_go_q, div_go_q;
	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [2*MUL_W-1:0]  mul_p;
	logic                mul_done, sqrt_done, div_done;
	logic [ROOT_W-1:0]   root;
	logic [QUO_W-1:0]    quo, quo_sat;
	logic [NUM_W-1:0]    div_num;
	logic signed [CROSS_W-1:0] sp;
	logic                out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;

	// Clamp the configured size to at least 2 and at most the grid the store can hold.
	always_comb begin
		if (int'(gsize_q) < 2) begin
			g_use = GW'(2);
		end else if (int'(gsize_q) > MAX_GRID) begin
			g_use = GW'(MAX_GRID);
		end else begin
			g_use = GW'(gsize_q);
		end
	end

	assign in_range = (int'(row) < int'(g_use)) && (int'(col) < int'(g_use));

	gsn_ram #(.WIDTH($bits(point_t)), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (accept && cmd == CMD_WRITE && in_range),
		.waddr (AW'(int'(row) * MAX_GRID + int'(col))),
		.wdata ({point_x, point_y, point_z}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Fetch the cell, the next row and the next column, one per cycle.
	always_comb begin
		case (state_q)
			S_RD1:   raddr = AW'((int'(r_q) + 1) * MAX_GRID + int'(c_q));
			S_RD2:   raddr = AW'(int'(r_q) * MAX_GRID + int'(c_q) + 1);
			default: raddr = AW'(int'(r_q) * MAX_GRID + int'(c_q));
		endcase
	end

	assign du[0] = diff(p10_q.x, p00_q.x);
	assign du[1] = diff(p10_q.y, p00_q.y);
	assign du[2] = diff(p10_q.z, p00_q.z);
	assign dv[0] = diff(p01_q.x, p00_q.x);
	assign dv[1] = diff(p01_q.y, p00_q.y);
	assign dv[2] = diff(p01_q.z, p00_q.z);

	// Cross product terms in order: uy*vz, uz*vy, uz*vx, ux*vz, ux*vy, uy*vx.
	always_comb begin
		case (k_q)
			3'd0:    begin ui = 2'd1; vi = 2'd2; end
			3'd1:    begin ui = 2'd2; vi = 2'd1; end
			3'd2:    begin ui = 2'd2; vi = 2'd0; end
			3'd3:    begin ui = 2'd0; vi = 2'd2; end
			3'd4:    begin ui = 2'd0; vi = 2'd1; end
			3'd5:    begin ui = 2'd1; vi = 2'd0; end
			default: begin ui = 2'd0; vi = 2'd0; end
		endcase
	end

	always_comb begin
		if (state_q == S_SQ) begin
			mul_a = a_q[k_q[1:0]][MUL_W-1:0];
			mul_b = a_q[k_q[1:0]][MUL_W-1:0];
		end else begin
			mul_a = MUL_W'(u_mag_q[ui]);
			mul_b = MUL_W'(v_mag_q[vi]);
		end
	end

	always_comb begin
		if (u_neg_q[ui] ^ v_neg_q[vi]) begin
			sp = -$signed({2'b00, mul_p[31:0]});
		end else begin
			sp = $signed({2'b00, mul_p[31:0]});
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			aval[i] = n_q[i][CROSS_W-1] ? CROSS_W'(-n_q[i]) : CROSS_W'(n_q[i]);
		end
		mx = aval[0];
		if (aval[1] > mx) mx = aval[1];
		if (aval[2] > mx) mx = aval[2];
	end

	assign div_num = NUM_W'({a_q[k_q[1:0]][MUL_W-1:0], FRAC_SH'(0)}) + NUM_W'(len_q >> 1);
	assign quo_sat = (quo > ONE_Q14) ? ONE_Q14 : quo;

	gsn_smul #(.W(MUL_W)) u_mul (
		.clk (clk), .arst_n (arst_n), .start (mul_go_q),
		.a (mul_a), .b (mul_b), .done (mul_done), .p (mul_p)
	);

	gsn_sqrt u_sqrt (
		.clk (clk), .arst_n (arst_n), .start (sqrt_go_q),
		.s (acc_q), .done (sqrt_done), .root (root)
	);

	gsn_div u_div (
		.clk (clk), .arst_n (arst_n), .start (div_go_q),
		.num (div_num), .den (len_q), .done (div_done), .quo (quo)
	);

	// Sequencer and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gsize_q <= GRID_RESET;
			out_valid_q <= 1'b0;
			k_q <= '0;
			mul_go_q <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (cfg_valid) begin
				gsize_q <= cfg_data;
			end
			// Drop the result once the receiver takes it.
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && cmd == CMD_READ) begin
						state_q <= in_range ? S_RD0 : S_DONE;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: state_q <= S_DIFF;
				S_DIFF: begin
					k_q <= '0;
					mul_go_q <= 1'b1;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul_done) begin
						if (k_q == 3'd5) begin
							state_q <= S_MAG;
						end else begin
							k_q <= k_q + 1'b1;
							mul_go_q <= 1'b1;
						end
					end
				end
				S_MAG: state_q <= (mx == '0) ? S_DONE : S_NORM;
				S_NORM: begin
					if (m_q < HI_LIM && m_q >= LO_LIM) begin
						k_q <= '0;
						mul_go_q <= 1'b1;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (mul_done) begin
						if (k_q == 3'd2) begin
							sqrt_go_q <= 1'b1;
							state_q <= S_SQRT;
						end else begin
							k_q <= k_q + 1'b1;
							mul_go_q <= 1'b1;
						end
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						k_q <= '0;
						div_go_q <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (k_q == 3'd2) begin
							state_q <= S_DONE;
						end else begin
							k_q <= k_q + 1'b1;
							div_go_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					// Load the output register once it is free or being taken.
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				// Last row and last column wrap to row 0 and column 0.
				r_q <= (int'(row) == int'(g_use) - 1) ? '0 : row;
				c_q <= (int'(col) == int'(g_use) - 1) ? '0 : col;
				for (int i = 0; i < 3; i++) begin
					res_n_q[i] <= '0;
				end
				res_st_q <= ST_OOR;
			end
			S_RD1: p00_q <= rdata;
			S_RD2: p10_q <= rdata;
			S_RD3: p01_q <= rdata;
			S_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					u_neg_q[i] <= du[i][DIFF_W-1];
					v_neg_q[i] <= dv[i][DIFF_W-1];
					u_mag_q[i] <= du[i][DIFF_W-1] ? MAG_W'(-du[i]) : MAG_W'(du[i]);
					v_mag_q[i] <= dv[i][DIFF_W-1] ? MAG_W'(-dv[i]) : MAG_W'(dv[i]);
				end
			end
			S_MUL: begin
				if (mul_done) begin
					if (!k_q[0]) begin
						n_q[k_q[2:1]] <= sp;
					end else begin
						n_q[k_q[2:1]] <= n_q[k_q[2:1]] - sp;
					end
				end
			end
			S_MAG: begin
				for (int i = 0; i < 3; i++) begin
					a_q[i] <= aval[i];
				end
				m_q <= mx;
				res_st_q <= ST_DEG;
				acc_q <= '0;
			end
			S_NORM: begin
				// One bit per cycle until the largest magnitude is in [2^29, 2^30).
				if (m_q >= HI_LIM) begin
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= a_q[i] >> 1;
					end
					m_q <= m_q >> 1;
				end else if (m_q < LO_LIM) begin
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= a_q[i] << 1;
					end
					m_q <= m_q << 1;
				end
			end
			S_SQ: begin
				if (mul_done) begin
					acc_q <= acc_q + SUM_W'(mul_p);
				end
			end
			S_SQRT: begin
				if (sqrt_done) begin
					len_q <= root;
				end
			end
			S_DIV: begin
				if (div_done) begin
					res_n_q[k_q[1:0]] <= n_q[k_q[1:0]][CROSS_W-1] ?
						-$signed(NRM_W'(quo_sat)) : $signed(NRM_W'(quo_sat));
					if (k_q == 3'd2) begin
						res_st_q <= ST_OK;
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					normal_x <= res_n_q[0];
					normal_y <= res_n_q[1];
					normal_z <= res_n_q[2];
					status <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

[hdl/gsn_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the grid surface normal unit, bound to the top level.
// Depends on gsn_pkg and grid_surface_normal_unit_top_assert.svh.
`include "grid_surface_normal_unit_top_assert.svh"

module gsn_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [gsn_pkg::CFG_W-1:0]          cfg_data,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               cmd,
	input logic [gsn_pkg::ROW_W-1:0]          row,
	input logic [gsn_pkg::ROW_W-1:0]          col,
	input logic signed [gsn_pkg::COORD_W-1:0] point_x,
	input logic signed [gsn_pkg::COORD_W-1:0] point_y,
	input logic signed [gsn_pkg::COORD_W-1:0] point_z,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [gsn_pkg::NRM_W-1:0]   normal_x,
	input logic signed [gsn_pkg::NRM_W-1:0]   normal_y,
	input logic signed [gsn_pkg::NRM_W-1:0]   normal_z,
	input logic [gsn_pkg::STAT_W-1:0]         status
);
	import gsn_pkg::*;

	localparam logic signed [NRM_W-1:0] NPOS = NRM_W'(ONE_Q14);
	localparam logic signed [NRM_W-1:0] NNEG = -NRM_W'(ONE_Q14);

	// A read occupies the block, so the next cycle must stall input.
	`GSN_ASSERT_NEXT(a_read_busy, clk, arst_n, in_valid && !in_stall && cmd == CMD_READ, in_stall, "read transfer did not stall input")

	// Failed reads carry a zero normal.
	`GSN_ASSERT_IMPLY(a_zero_on_fail, clk, arst_n, out_valid && status != ST_OK, normal_x == 0 && normal_y == 0 && normal_z == 0, "nonzero normal with error status")

	// Good normals stay within plus and minus one.
	`GSN_ASSERT_IMPLY(a_unit_range, clk, arst_n, out_valid && status == ST_OK, normal_x >= NNEG && normal_x <= NPOS && normal_y >= NNEG && normal_y <= NPOS && normal_z >= NNEG && normal_z <= NPOS, "normal component out of range")

	// A stalled result holds.
	`GSN_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(normal_x) && $stable(status), "stalled result changed")
endmodule

bind grid_surface_normal_unit_top gsn_checker u_gsn_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for grid_surface_normal_unit_top: queued stimulus, a clocked driver
// and monitor, and an in-bench normal calculator that predicts every read result.
// Depends on gsn_pkg and the RTL of the unit.
module tb_top;
	import gsn_pkg::*;

	localparam int GRID_MAX = 32;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 500;
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		logic cmd;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		coord_t px;
		coord_t py;
		coord_t pz;
	} item_t;

	typedef struct {
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
		logic [STAT_W-1:0] st;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_WRITE;
	logic [ROW_W-1:0] row = '0;
	logic [ROW_W-1:0] col = '0;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic signed [COORD_W-1:0] point_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [NRM_W-1:0] normal_x;
	logic signed [NRM_W-1:0] normal_y;
	logic signed [NRM_W-1:0] normal_z;
	logic [STAT_W-1:0] status;

	item_t pending_items[$];
	normal_t expected_normals[$];
	item_t cur_item;

	// Predictor state: mirrored point store and grid size register.
	coord_t mir_x[GRID_MAX*GRID_MAX];
	coord_t mir_y[GRID_MAX*GRID_MAX];
	coord_t mir_z[GRID_MAX*GRID_MAX];
	logic [CFG_W-1:0] grid_shadow = GRID_RESET;

	// Stimulus-side record of which cells hold a written point.
	bit gen_written[GRID_MAX*GRID_MAX];
	int gen_grid;

	int errors = 0;
	int idle_cycles = 0;
	logic quiet = 1'b0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int hold_cnt = 0;

	grid_surface_normal_unit_top #(.MAX_GRID(GRID_MAX)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .row(row), .col(col),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.status(status)
	);

	always #5 clk = ~clk;

	function automatic int clamp_grid(logic [CFG_W-1:0] g);
		int v;
		v = g;
		if (v < 2) v = 2;
		if (v > GRID_MAX) v = GRID_MAX;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Cross product of the row and column tangents, normalized to Q1.14.
	function automatic normal_t calc_normal(logic [ROW_W-1:0] r_in, logic [ROW_W-1:0] c_in);
		normal_t res;
		int g, r, c, i00, i10, i01, sh;
		longint ux, uy, uz, vx, vy, vz;
		longint n[3];
		longint unsigned a[3];
		longint unsigned m, sum, len, q;
		res = '{0, 0, 0, ST_OK};
		g = clamp_grid(grid_shadow);
		if (r_in >= g || c_in >= g) begin
			res.st = ST_OOR;
			return res;
		end
		r = (r_in == g - 1) ? 0 : r_in;
		c = (c_in == g - 1) ? 0 : c_in;
		i00 = r * GRID_MAX + c;
		i10 = (r + 1) * GRID_MAX + c;
		i01 = r * GRID_MAX + c + 1;
		ux = longint'(mir_x[i10]) - longint'(mir_x[i00]);
		uy = longint'(mir_y[i10]) - longint'(mir_y[i00]);
		uz = longint'(mir_z[i10]) - longint'(mir_z[i00]);
		vx = longint'(mir_x[i01]) - longint'(mir_x[i00]);
		vy = longint'(mir_y[i01]) - longint'(mir_y[i00]);
		vz = longint'(mir_z[i01]) - longint'(mir_z[i00]);
		n[0] = uy * vz - uz * vy;
		n[1] = uz * vx - ux * vz;
		n[2] = ux * vy - uy * vx;
		m = 0;
		for (int k = 0; k < 3; k++) begin
			a[k] = (n[k] < 0) ? longint'(-n[k]) : longint'(n[k]);
			if (a[k] > m) m = a[k];
		end
		if (m == 0) begin
			res.st = ST_DEG;
			return res;
		end
		sh = 0;
		if (m >= (64'd1 << 30)) begin
			while ((m >> sh) >= (64'd1 << 30)) sh++;
			for (int k = 0; k < 3; k++) a[k] = a[k] >> sh;
		end else begin
			while ((m << sh) < (64'd1 << 29)) sh++;
			for (int k = 0; k < 3; k++) a[k] = a[k] << sh;
		end
		sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		len = int_sqrt(sum);
		for (int k = 0; k < 3; k++) begin
			q = (a[k] * 16384 + (len >> 1)) / len;
			if (q > 16384) q = 16384;
			case (k)
				0: res.nx = (n[k] < 0) ? -q[NRM_W-1:0] : q[NRM_W-1:0];
				1: res.ny = (n[k] < 0) ? -q[NRM_W-1:0] : q[NRM_W-1:0];
				default: res.nz = (n[k] < 0) ? -q[NRM_W-1:0] : q[NRM_W-1:0];
			endcase
		end
		return res;
	endfunction

	// Apply one accepted transfer to the mirrored state.
	task automatic absorb_item(item_t it);
		int g;
		g = clamp_grid(grid_shadow);
		if (it.cmd == CMD_WRITE) begin
			if (it.row < g && it.col < g) begin
				mir_x[it.row * GRID_MAX + it.col] = it.px;
				mir_y[it.row * GRID_MAX + it.col] = it.py;
				mir_z[it.row * GRID_MAX + it.col] = it.pz;
			end
		end else begin
			expected_normals.push_back(calc_normal(it.row, it.col));
		end
	endtask

	// Driver: advance to the next queued item after each transfer, idle at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) absorb_item(cur_item);
			if (!in_valid || !in_stall) begin
				if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 35)) begin
					cur_item = pending_items.pop_front();
					in_valid <= 1'b1;
					cmd <= cur_item.cmd;
					row <= cur_item.row;
					col <= cur_item.col;
					point_x <= cur_item.px;
					point_y <= cur_item.py;
					point_z <= cur_item.pz;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here so the block backs up and stalls its input.
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Monitor: compare each result transfer against the oldest expected normal.
	always @(posedge clk or negedge arst_n) begin
		normal_t exp_n;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_normals.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: n=(%0d,%0d,%0d) status=%0d",
							normal_x, normal_y, normal_z, status);
				end else begin
					exp_n = expected_normals.pop_front();
					if (normal_x !== exp_n.nx || normal_y !== exp_n.ny ||
						normal_z !== exp_n.nz || status !== exp_n.st) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected n=(%0d,%0d,%0d) st=%0d, got n=(%0d,%0d,%0d) st=%0d",
								exp_n.nx, exp_n.ny, exp_n.nz, exp_n.st,
								normal_x, normal_y, normal_z, status);
					end
				end
			end
			out_stall <= (hold_cnt > 0) || (!quiet && $urandom_range(99) < 35);
		end
	end

	// Watchdog: count cycles without any transfer on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Queue one item and track which cells the block will hold.
	task automatic push_item(logic c, int r, int cl, coord_t x, coord_t y, coord_t z);
		item_t it;
		it.cmd = c;
		it.row = r[ROW_W-1:0];
		it.col = cl[ROW_W-1:0];
		it.px = x;
		it.py = y;
		it.pz = z;
		if (c == CMD_WRITE && r < gen_grid && cl < gen_grid) gen_written[r * GRID_MAX + cl] = 1'b1;
		pending_items.push_back(it);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sd0;
			3, 4, 5: return coord_t'($urandom);
			default: return coord_t'($urandom_range(8191) - 4096);
		endcase
	endfunction

	// Cells a read of (r, cl) uses, after wrapping the last row and column.
	task automatic cell_set(int r, int cl, output int i00, output int i10, output int i01);
		int rr, cc;
		rr = (r == gen_grid - 1) ? 0 : r;
		cc = (cl == gen_grid - 1) ? 0 : cl;
		i00 = rr * GRID_MAX + cc;
		i10 = (rr + 1) * GRID_MAX + cc;
		i01 = rr * GRID_MAX + cc + 1;
	endtask

	// One phase of random traffic, mostly write-then-read sequences.
	task automatic random_phase(int n_items);
		int r, cl, i00, i10, i01, pick, target;
		bit degen;
		coord_t dx, dy, dz;
		target = pending_items.size() + n_items;
		while (pending_items.size() < target) begin
			pick = $urandom_range(99);
			r = $urandom_range(gen_grid - 1);
			cl = $urandom_range(gen_grid - 1);
			if (pick < 70) begin
				cell_set(r, cl, i00, i10, i01);
				degen = ($urandom_range(99) < 8);
				dx = rand_coord();
				dy = rand_coord();
				dz = rand_coord();
				if (degen || !gen_written[i00] || $urandom_range(1))
					push_item(CMD_WRITE, i00 / GRID_MAX, i00 % GRID_MAX, dx, dy, dz);
				if (degen || !gen_written[i10] || $urandom_range(1))
					push_item(CMD_WRITE, i10 / GRID_MAX, i10 % GRID_MAX,
						degen ? dx : rand_coord(), degen ? dy : rand_coord(),
						degen ? dz : rand_coord());
				if (degen || !gen_written[i01] || $urandom_range(1))
					push_item(CMD_WRITE, i01 / GRID_MAX, i01 % GRID_MAX,
						degen ? dx : rand_coord(), degen ? dy : rand_coord(),
						degen ? dz : rand_coord());
				push_item(CMD_READ, r, cl, coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom));
			end else if (pick < 85) begin
				push_item(CMD_WRITE, $urandom_range(31), $urandom_range(31),
					rand_coord(), rand_coord(), rand_coord());
			end else begin
				// Out-of-range read when the grid leaves room and the pick allows, else a read of a ready cell.
				if (gen_grid < GRID_MAX && pick < 95) begin
					if ($urandom_range(1)) r = $urandom_range(31, gen_grid);
					else cl = $urandom_range(31, gen_grid);
					push_item(CMD_READ, r, cl, coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom));
				end else begin
					cell_set(r, cl, i00, i10, i01);
					if (gen_written[i00] && gen_written[i10] && gen_written[i01])
						push_item(CMD_READ, r, cl, '0, '0, '0);
				end
			end
		end
	endtask

	// Wait until every item is in and every result is out, then let the block settle.
	// Sample on the falling edge so the driver's updates of the rising edge are visible.
	task automatic drain();
		do @(negedge clk);
		while (pending_items.size() > 0 || in_valid || expected_normals.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_grid(logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk);
		while (!cfg_ready);
		grid_shadow = v;
		cfg_valid <= 1'b0;
		gen_grid = clamp_grid(v);
	endtask

	initial begin
		logic [CFG_W-1:0] grids[6];
		gen_grid = clamp_grid(GRID_RESET);

		// Directed: axis normal, extreme coordinates, degenerate cell, wraps, out-of-range.
		push_item(CMD_WRITE, 0, 0, 16'sd0, 16'sd0, 16'sd0);
		push_item(CMD_WRITE, 1, 0, 16'sd4096, 16'sd0, 16'sd0);
		push_item(CMD_WRITE, 0, 1, 16'sd0, 16'sd4096, 16'sd0);
		push_item(CMD_READ, 0, 0, '0, '0, '0);
		push_item(CMD_WRITE, 2, 2, 16'sh8000, 16'sh8000, 16'sh8000);
		push_item(CMD_WRITE, 3, 2, 16'sh7fff, 16'sh8000, 16'sh7fff);
		push_item(CMD_WRITE, 2, 3, 16'sh8000, 16'sh7fff, 16'sh7fff);
		push_item(CMD_READ, 2, 2, 16'shffff, 16'shffff, 16'shffff);
		push_item(CMD_WRITE, 5, 5, 16'sd100, -16'sd200, 16'sd300);
		push_item(CMD_WRITE, 6, 5, 16'sd100, -16'sd200, 16'sd300);
		push_item(CMD_WRITE, 5, 6, 16'sd100, -16'sd200, 16'sd300);
		push_item(CMD_READ, 5, 5, '0, '0, '0);
		push_item(CMD_READ, 19, 19, '0, '0, '0);
		push_item(CMD_READ, 19, 0, '0, '0, '0);
		push_item(CMD_READ, 0, 19, '0, '0, '0);
		push_item(CMD_READ, 20, 3, '0, '0, '0);
		push_item(CMD_READ, 31, 31, '0, '0, '0);
		push_item(CMD_WRITE, 25, 25, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		push_item(CMD_WRITE, 31, 0, 16'sh8000, 16'sh0001, 16'sh1234);
		push_item(CMD_READ, 3, 31, '0, '0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// Includes both clamped ends and both legal extremes of the grid size.
		grids = '{6'd2, 6'd32, 6'd0, 6'd63, 6'd7, 6'($urandom_range(2, 32))};
		foreach (grids[p]) begin
			write_grid(grids[p]);
			@(negedge clk);
			quiet <= (p == 4);
			hold_go <= (p == 1);
			random_phase(260);
			drain();
		end
		quiet <= 1'b0;

		errors += expected_normals.size();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
